/* src/pressure_sensor_compensation_core_assert.svh */
// assertion macros for the pressure sensor compensation core
// no dependencies; SYNTH leaves the macros empty
`ifndef PRESSURE_SENSOR_COMPENSATION_CORE_ASSERT_SVH
`define PRESSURE_SENSOR_COMPENSATION_CORE_ASSERT_SVH
`ifndef SYNTH
`define PSC_ASSERT_IMPL(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PSC_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define PSC_ASSERT_IMPL(label, a, c)
`define PSC_ASSERT_NEXT(label, a, c)
`endif
`endif

/* src/psc_pkg.sv */
// shared types, opcodes and constants for the compensation core
// no dependencies
package psc_pkg;
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [1:0] REG_CAL_A = 2'd0;
    localparam logic [1:0] REG_CAL_B = 2'd1;
    localparam logic [1:0] REG_CAL_C = 2'd2;
    localparam logic [1:0] REG_OSS   = 2'd3;

    // datapath micro operations
    typedef enum logic [4:0] {
        OP_NOP    = 5'd0,
        OP_LOAD   = 5'd1,   // latch input, t0 = ut - ac6 or b6, up
        OP_T_MUL  = 5'd2,   // acc = t0 * ac5
        OP_T_X1   = 5'd3,   // x1 = acc >>> 15, den = x1 + md
        OP_DIV_S  = 5'd4,   // start signed divide num/den
        OP_T_B5   = 5'd5,   // b5 = x1 + q, result
        OP_P_SQ   = 5'd6,   // acc = b6*b6
        OP_P_SQS  = 5'd7,   // sq = acc >>> 12
        OP_P_M1   = 5'd8,   // acc = b2*sq
        OP_P_M1S  = 5'd9,   // x3 = acc >>> 11
        OP_P_M2   = 5'd10,  // acc = ac2*b6
        OP_P_B3   = 5'd11,  // b3
        OP_P_M3   = 5'd12,  // acc = ac3*b6
        OP_P_M3S  = 5'd13,  // x1 = acc >>> 13
        OP_P_M4   = 5'd14,  // acc = b1*sq
        OP_P_X3   = 5'd15,  // x3 = (x1 + acc>>>16 + 2) >>> 2
        OP_P_B4M  = 5'd16,  // acc = ac4*(x3+32768)
        OP_P_B4   = 5'd17,  // b4 = acc >> 15
        OP_P_B7M  = 5'd18,  // acc = (up-b3)*(50000>>oss)
        OP_DIV_U  = 5'd19,  // start unsigned divide
        OP_P_Q    = 5'd20,  // p from quotient
        OP_P_F1   = 5'd21,  // acc = (p>>>8)^2
        OP_P_F2   = 5'd22,  // acc = acc*3038 -> x1
        OP_P_F3   = 5'd23,  // acc = -7357*p
        OP_P_FIN  = 5'd24,  // final p
        OP_FAIL   = 5'd25   // divisor zero
    } op_t;

    typedef struct packed {
        op_t op;
    } psc_cmd_t;

    typedef struct packed {
        logic kind;
        logic div_busy;
        logic div_zero;
    } psc_stat_t;

    localparam logic signed [31:0] B6_OFS = 32'sd4000;
    localparam logic signed [31:0] C3038  = 32'sd3038;
    localparam logic signed [31:0] CM7357 = -32'sd7357;
    localparam logic signed [31:0] C3791  = 32'sd3791;
    localparam logic [31:0]        C50000 = 32'd50000;
    localparam logic [31:0]        C32768 = 32'd32768;
    localparam logic [31:0]        TOP    = 32'h8000_0000;
endpackage

/* src/psc_divider.sv */
// radix-2 restoring divider, 32-bit unsigned, one quotient bit per cycle
// depends on psc_pkg
module psc_divider
    import psc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] trial;

    assign trial = {r_reg, q_reg[31]} - {1'b0, d_reg};

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = 6'd32;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (!trial[32])
            begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = (cnt_reg != 6'd0);
    assign quotient = q_reg;
endmodule

/* src/psc_datapath.sv */
// compensation datapath: one shared multiplier, divider, working registers
// depends on psc_pkg, psc_divider and the assertion header
`include "pressure_sensor_compensation_core_assert.svh"
module psc_datapath
    import psc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  psc_cmd_t           cmd,
    input  logic               kind,
    input  logic [23:0]        raw_value,
    input  logic [63:0]        cal_a,
    input  logic [63:0]        cal_b,
    input  logic [47:0]        cal_c,
    input  logic [1:0]         oss,
    output psc_stat_t          stat,
    output logic signed [31:0] res_value,
    output logic               res_error
);
    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [31:0] ac4, ac5, ac6;
    logic        kind_reg;
    logic [31:0] up_reg, up_next;
    logic signed [31:0] t0_reg, t0_next;     // ut-ac6 or b6
    logic signed [31:0] x1_reg, x1_next;
    logic signed [31:0] x3_reg, x3_next;     // also den / b4
    logic signed [31:0] sq_reg, sq_next;
    logic signed [31:0] b3_reg, b3_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] tt_reg, tt_next;
    logic signed [31:0] val_reg, val_next;
    logic        err_reg, err_next;
    logic        neg_reg, neg_next;
    logic signed [31:0] ma, mb;
    logic [63:0] prod;
    logic        div_start;
    logic [31:0] div_a, div_b, div_q;
    logic        div_busy;
    logic signed [31:0] tmp, num, pa;

    assign ac1 = 32'(signed'(cal_a[63:48]));
    assign ac2 = 32'(signed'(cal_a[47:32]));
    assign ac3 = 32'(signed'(cal_a[31:16]));
    assign ac4 = {16'd0, cal_a[15:0]};
    assign ac5 = {16'd0, cal_b[63:48]};
    assign ac6 = {16'd0, cal_b[47:32]};
    assign b1  = 32'(signed'(cal_b[31:16]));
    assign b2  = 32'(signed'(cal_b[15:0]));
    assign mc  = 32'(signed'(cal_c[31:16]));
    assign md  = 32'(signed'(cal_c[15:0]));
    assign num = mc <<< 11;
    assign pa  = val_reg >>> 8;

    // operand select for the shared multiplier
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (cmd.op)
            OP_T_MUL: begin ma = t0_reg; mb = signed'(ac5); end
            OP_P_SQ:  begin ma = t0_reg; mb = t0_reg; end
            OP_P_M1:  begin ma = b2; mb = sq_reg; end
            OP_P_M2:  begin ma = ac2; mb = t0_reg; end
            OP_P_M3:  begin ma = ac3; mb = t0_reg; end
            OP_P_M4:  begin ma = b1; mb = sq_reg; end
            OP_P_B4M: begin ma = signed'(ac4); mb = x3_reg + signed'(C32768); end
            OP_P_B7M: begin ma = signed'(up_reg) - b3_reg; mb = signed'(C50000 >> oss); end
            OP_P_F1:  begin ma = pa; mb = pa; end
            OP_P_F2:  begin ma = acc_reg; mb = C3038; end
            OP_P_F3:  begin ma = CM7357; mb = val_reg; end
            default:  begin ma = '0; mb = '0; end
        endcase
    end
    assign prod = {32'd0, ma} * {32'd0, mb};

    always_comb
    begin
        up_next = up_reg; t0_next = t0_reg; x1_next = x1_reg; x3_next = x3_reg;
        sq_next = sq_reg; b3_next = b3_reg; acc_next = acc_reg; tt_next = tt_reg;
        val_next = val_reg; err_next = err_reg; neg_next = neg_reg;
        div_start = 1'b0; div_a = '0; div_b = '0; tmp = '0;
        unique case (cmd.op)
            OP_LOAD:
            begin
                err_next = 1'b0;
                up_next = {8'd0, raw_value} >> (4'd8 - {2'b0, oss});
                if (kind)
                    t0_next = tt_reg - B6_OFS;
                else
                    t0_next = signed'({16'd0, raw_value[15:0]}) - signed'(ac6);
            end
            OP_T_MUL, OP_P_SQ, OP_P_M1, OP_P_M2, OP_P_M3, OP_P_M4,
            OP_P_B4M, OP_P_B7M, OP_P_F1, OP_P_F3:
                acc_next = signed'(prod[31:0]);
            OP_P_F2:
                x1_next = signed'(prod[31:0]) >>> 16;
            OP_T_X1:
            begin
                x1_next = acc_reg >>> 15;
                x3_next = (acc_reg >>> 15) + md;
            end
            OP_DIV_S:
            begin
                div_start = 1'b1;
                neg_next = num[31] ^ x3_reg[31];
                div_a = num[31] ? -num : num;
                div_b = x3_reg[31] ? -x3_reg : x3_reg;
            end
            OP_T_B5:
            begin
                tmp = x1_reg + (neg_reg ? -signed'(div_q) : signed'(div_q));
                tt_next = tmp;
                val_next = (tmp + 32'sd8) >>> 4;
            end
            OP_P_SQS: sq_next = acc_reg >>> 12;
            OP_P_M1S: x3_next = acc_reg >>> 11;
            OP_P_B3:
            begin
                tmp = x3_reg + (acc_reg >>> 11);
                b3_next = (((ac1 <<< 2) + tmp) <<< oss) + 32'sd2 >>> 2;
            end
            OP_P_M3S: x1_next = acc_reg >>> 13;
            OP_P_X3:  x3_next = (x1_reg + (acc_reg >>> 16) + 32'sd2) >>> 2;
            // b4 is a logical shift, upper bits zero
            OP_P_B4:  x3_next = signed'({15'd0, acc_reg[31:15]});
            OP_DIV_U:
            begin
                div_start = 1'b1;
                div_a = (acc_reg[31]) ? acc_reg : {acc_reg[30:0], 1'b0};
                div_b = x3_reg;
                neg_next = acc_reg[31];
            end
            OP_P_Q:
                val_next = neg_reg ? signed'({div_q[30:0], 1'b0}) : signed'(div_q);
            OP_P_FIN:
                val_next = val_reg + ((x1_reg + (acc_reg >>> 16) + C3791) >>> 4);
            OP_FAIL:
            begin
                err_next = 1'b1;
                val_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tt_reg <= '0;
            err_reg <= 1'b0;
            kind_reg <= 1'b0;
        end
        else
        begin
            tt_reg <= tt_next;
            err_reg <= err_next;
            if (cmd.op == OP_LOAD)
                kind_reg <= kind;
        end
    end

    always_ff @(posedge clk)
    begin
        up_reg <= up_next; t0_reg <= t0_next; x1_reg <= x1_next; x3_reg <= x3_next;
        sq_reg <= sq_next; b3_reg <= b3_next; acc_reg <= acc_next;
        val_reg <= val_next; neg_reg <= neg_next;
    end

    psc_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_b), .busy(div_busy), .quotient(div_q)
    );

    assign stat.kind = kind_reg;
    assign stat.div_busy = div_busy;
    assign stat.div_zero = (x3_reg == 32'sd0);
    assign res_value = val_reg;
    assign res_error = err_reg;

    `PSC_ASSERT_IMPL(a_fail_zero, err_reg, val_reg == 32'sd0)
    `PSC_ASSERT_NEXT(a_div_busy, div_start, div_busy)
    `PSC_ASSERT_NEXT(a_tt_keep, cmd.op == OP_FAIL, tt_reg == $past(tt_reg))
endmodule

/* src/psc_ctrl.sv */
// sequencer stepping the datapath through the compensation formulas
// depends on psc_pkg and the assertion header
`include "pressure_sensor_compensation_core_assert.svh"
module psc_ctrl
    import psc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  psc_stat_t stat,
    output psc_cmd_t  cmd
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        cmd.op = OP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_RUN;
                    op_next = OP_NOP;
                end
            end
            S_RUN:
            begin
                if (op_reg == OP_NOP)
                    op_next = stat.kind ? OP_P_SQ : OP_T_MUL;
                else
                begin
                    cmd.op = op_reg;
                    priority case (op_reg)
                        OP_T_MUL: op_next = OP_T_X1;
                        OP_T_X1:  op_next = OP_DIV_S;
                        OP_DIV_S: if (stat.div_zero)
                                  begin
                                      cmd.op = OP_FAIL;
                                      state_next = S_DONE;
                                  end
                                  else
                                  begin
                                      op_next = OP_T_B5;
                                      state_next = S_WAIT;
                                  end
                        OP_T_B5:  state_next = S_DONE;
                        OP_P_SQ:  op_next = OP_P_SQS;
                        OP_P_SQS: op_next = OP_P_M1;
                        OP_P_M1:  op_next = OP_P_M1S;
                        OP_P_M1S: op_next = OP_P_M2;
                        OP_P_M2:  op_next = OP_P_B3;
                        OP_P_B3:  op_next = OP_P_M3;
                        OP_P_M3:  op_next = OP_P_M3S;
                        OP_P_M3S: op_next = OP_P_M4;
                        OP_P_M4:  op_next = OP_P_X3;
                        OP_P_X3:  op_next = OP_P_B4M;
                        OP_P_B4M: op_next = OP_P_B4;
                        OP_P_B4:  op_next = OP_P_B7M;
                        OP_P_B7M: op_next = OP_DIV_U;
                        OP_DIV_U: if (stat.div_zero)
                                  begin
                                      cmd.op = OP_FAIL;
                                      state_next = S_DONE;
                                  end
                                  else
                                  begin
                                      op_next = OP_P_Q;
                                      state_next = S_WAIT;
                                  end
                        OP_P_Q:   op_next = OP_P_F1;
                        OP_P_F1:  op_next = OP_P_F2;
                        OP_P_F2:  op_next = OP_P_F3;
                        OP_P_F3:  op_next = OP_P_FIN;
                        OP_P_FIN: state_next = S_DONE;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_WAIT:
            begin
                if (!stat.div_busy)
                    state_next = S_RUN;
            end
            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_NOP;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
        end
    end

    `PSC_ASSERT_IMPL(a_onehot, 1'b1, $onehot(state_reg))
    `PSC_ASSERT_IMPL(a_excl, in_ready, !out_valid)
    `PSC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)
endmodule

/* src/pressure_sensor_compensation_core.sv */
// top level of the pressure sensor compensation core
// depends on psc_pkg, psc_ctrl, psc_datapath
//
// channel   dir  handshake            payload
// input     in   in_valid/in_ready    kind, raw_value
// result    out  out_valid/out_ready  result_kind, value, error
// config    in   cfg_we               cfg_index, cfg_data
//
// one item at a time; the run time of both temperature and pressure is set
// by the serial divider and the shared multiplier
// reset clears configuration, the stored b5 term and the sequencer
// a result holds until out_ready; no new item is taken meanwhile
module pressure_sensor_compensation_core
    import psc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [23:0]        raw_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               result_kind,
    output logic signed [31:0] value,
    output logic               error,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    logic [63:0] cal_a_reg, cal_b_reg;
    logic [47:0] cal_c_reg;
    logic [1:0]  oss_reg;
    psc_cmd_t    cmd;
    psc_stat_t   stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            oss_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAL_A: cal_a_reg <= cfg_data;
                REG_CAL_B: cal_b_reg <= cfg_data;
                REG_CAL_C: cal_c_reg <= cfg_data[47:0];
                REG_OSS:   oss_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    psc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
    );

    psc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .kind(kind), .raw_value(raw_value),
        .cal_a(cal_a_reg), .cal_b(cal_b_reg), .cal_c(cal_c_reg), .oss(oss_reg),
        .stat(stat), .res_value(value), .res_error(error)
    );

    assign result_kind = stat.kind;
endmodule
